/* src/cdps_pkg.sv */
// Shared types and constants for the clock divider pair search unit.
`timescale 1ns / 1ps
`default_nettype none

package cdps_pkg;

  localparam int RATE_W       = 31;
  localparam int PRE_FIELD_W  = 4;
  localparam int POST_FIELD_W = 7;
  localparam int NUM_W        = RATE_W + 1;
  localparam int PRE_MAX_DEF  = 8;
  localparam int POST_MAX_DEF = 64;

  localparam logic [RATE_W-1:0] START_DISTANCE = {RATE_W{1'b1}};

  typedef enum logic [1:0] {
    DSEL_PRE,
    DSEL_POST,
    DSEL_UP1,
    DSEL_UP2
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRE_START,
    ST_PRE_WAIT,
    ST_POST_START,
    ST_POST_WAIT,
    ST_CMP,
    ST_UP1_START,
    ST_UP1_WAIT,
    ST_UP2_START,
    ST_UP2_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     stage_cap;
    logic     dist_cap;
    logic     compare;
    logic     pre_inc;
    logic     post_inc;
    logic     ceil_cap;
    logic     result_cap;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic pre_last;
    logic post_last;
  } dp_stat_t;

endpackage

`default_nettype wire

/* src/cdps_div.sv */
// Restoring divider that produces one quotient bit per clock cycle.
`timescale 1ns / 1ps
`default_nettype none

module cdps_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 7
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] dividend,
  input  wire logic [DEN_W-1:0] divisor,
  output logic                  done,
  output logic [NUM_W-1:0]      quotient
);

  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic             active;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   trial;
  logic             q_bit;

  always_comb begin
    trial = {rem, num[NUM_W-1]};
    q_bit = (trial >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(NUM_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      den <= divisor;
      rem <= '0;
    end else if (active) begin
      // The remainder stays below the divisor, so it fits DEN_W bits.
      if (q_bit) begin
        rem <= DEN_W'(trial - {1'b0, den});
      end else begin
        rem <= trial[DEN_W-1:0];
      end
      num <= {num[NUM_W-2:0], q_bit};
    end
  end

  assign quotient = num;

endmodule

`default_nettype wire

/* src/cdps_datapath.sv */
// Datapath: operand registers, divider, distance compare and result registers.
`timescale 1ns / 1ps
`default_nettype none

module cdps_datapath #(
  parameter int PRE_MAX  = cdps_pkg::PRE_MAX_DEF,
  parameter int POST_MAX = cdps_pkg::POST_MAX_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire cdps_pkg::dp_cmd_t                    cmd,
  output cdps_pkg::dp_stat_t                        stat,
  input  wire logic [cdps_pkg::RATE_W-1:0]          target_rate,
  input  wire logic [cdps_pkg::RATE_W-1:0]          source_rate,
  output logic      [cdps_pkg::PRE_FIELD_W-1:0]     pre_divisor,
  output logic      [cdps_pkg::POST_FIELD_W-1:0]    post_divisor,
  output logic      [cdps_pkg::RATE_W-1:0]          rounded_rate,
  output logic                                      found
);

  import cdps_pkg::*;

  localparam int PW  = $clog2(PRE_MAX + 1);
  localparam int SW  = $clog2(POST_MAX + 1);
  localparam int DVW = (PW > SW) ? PW : SW;

  logic [RATE_W-1:0] target;
  logic [RATE_W-1:0] parent;
  logic [RATE_W-1:0] stage;
  logic [RATE_W-1:0] distance;
  logic [RATE_W-1:0] best;
  logic [RATE_W-1:0] ceil1;
  logic [PW-1:0]     pre_cnt;
  logic [SW-1:0]     post_cnt;
  logic [PW-1:0]     pre_sel;
  logic [SW-1:0]     post_sel;
  logic              hit;

  logic [NUM_W-1:0]  div_num;
  logic [DVW-1:0]    div_den;
  logic              div_done;
  logic [NUM_W-1:0]  div_quot;
  logic [RATE_W-1:0] q;

  always_comb begin
    case (cmd.div_sel)
      DSEL_PRE: begin
        div_num = {1'b0, parent};
        div_den = DVW'(pre_cnt);
      end
      DSEL_POST: begin
        div_num = {1'b0, stage};
        div_den = DVW'(post_cnt);
      end
      DSEL_UP1: begin
        div_num = {1'b0, parent} + NUM_W'(pre_sel) - NUM_W'(1);
        div_den = DVW'(pre_sel);
      end
      DSEL_UP2: begin
        div_num = {1'b0, ceil1} + NUM_W'(post_sel) - NUM_W'(1);
        div_den = DVW'(post_sel);
      end
      default: begin
        div_num = '0;
        div_den = DVW'(1);
      end
    endcase
  end

  cdps_div #(
    .NUM_W(NUM_W),
    .DEN_W(DVW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .dividend(div_num),
    .divisor (div_den),
    .done    (div_done),
    .quotient(div_quot)
  );

  assign q = div_quot[RATE_W-1:0];

  assign stat.div_done  = div_done;
  assign stat.pre_last  = (pre_cnt == PW'(PRE_MAX));
  assign stat.post_last = (post_cnt == SW'(POST_MAX));

  assign hit = (distance < best);

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_cnt  <= PW'(1);
      post_cnt <= SW'(1);
      pre_sel  <= PW'(1);
      post_sel <= SW'(1);
      best     <= START_DISTANCE;
      found    <= 1'b0;
    end else begin
      if (cmd.load) begin
        pre_cnt  <= PW'(1);
        post_cnt <= SW'(1);
        pre_sel  <= PW'(1);
        post_sel <= SW'(1);
        best     <= START_DISTANCE;
        found    <= 1'b0;
      end else begin
        if (cmd.compare && hit) begin
          best     <= distance;
          pre_sel  <= pre_cnt;
          post_sel <= post_cnt;
          found    <= 1'b1;
        end
        if (cmd.pre_inc) begin
          pre_cnt <= pre_cnt + PW'(1);
        end
        if (cmd.stage_cap) begin
          post_cnt <= SW'(1);
        end else if (cmd.post_inc) begin
          post_cnt <= post_cnt + SW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      target <= target_rate;
      parent <= source_rate;
    end
    if (cmd.stage_cap) begin
      stage <= q;
    end
    if (cmd.dist_cap) begin
      distance <= (q >= target) ? (q - target) : (target - q);
    end
    if (cmd.ceil_cap) begin
      ceil1 <= q;
    end
    if (cmd.result_cap) begin
      rounded_rate <= q;
      pre_divisor  <= PRE_FIELD_W'(pre_sel);
      post_divisor <= POST_FIELD_W'(post_sel);
    end
  end

endmodule

`default_nettype wire

/* src/cdps_ctrl.sv */
// Controller state machine that sequences the divider pair search.
`timescale 1ns / 1ps
`default_nettype none

module cdps_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire cdps_pkg::dp_stat_t stat,
  output cdps_pkg::dp_cmd_t       cmd,
  output logic                    busy,
  output logic                    done
);

  import cdps_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_PRE_START;
      end
      ST_PRE_START:  state_next = ST_PRE_WAIT;
      ST_PRE_WAIT: begin
        if (stat.div_done) state_next = ST_POST_START;
      end
      ST_POST_START: state_next = ST_POST_WAIT;
      ST_POST_WAIT: begin
        if (stat.div_done) state_next = ST_CMP;
      end
      ST_CMP: begin
        if (!stat.post_last) begin
          state_next = ST_POST_START;
        end else if (!stat.pre_last) begin
          state_next = ST_PRE_START;
        end else begin
          state_next = ST_UP1_START;
        end
      end
      ST_UP1_START:  state_next = ST_UP1_WAIT;
      ST_UP1_WAIT: begin
        if (stat.div_done) state_next = ST_UP2_START;
      end
      ST_UP2_START:  state_next = ST_UP2_WAIT;
      ST_UP2_WAIT: begin
        if (stat.div_done) state_next = ST_DONE;
      end
      ST_DONE:       state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.div_sel = DSEL_PRE;
    case (state)
      ST_IDLE:       cmd.load = start;
      ST_PRE_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_PRE;
      end
      ST_PRE_WAIT:   cmd.stage_cap = stat.div_done;
      ST_POST_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_POST;
      end
      ST_POST_WAIT:  cmd.dist_cap = stat.div_done;
      ST_CMP: begin
        cmd.compare  = 1'b1;
        cmd.post_inc = !stat.post_last;
        cmd.pre_inc  = stat.post_last && !stat.pre_last;
      end
      ST_UP1_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_UP1;
      end
      ST_UP1_WAIT:   cmd.ceil_cap = stat.div_done;
      ST_UP2_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_UP2;
      end
      ST_UP2_WAIT:   cmd.result_cap = stat.div_done;
      default:       cmd.div_sel = DSEL_PRE;
    endcase
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);

  // The divider is only ever started while no division is finishing.
  assert property (@(posedge clk) disable iff (rst) cmd.div_start |-> !stat.div_done)
    else $error("divider started while a division was completing");

  // A comparison always follows a completed post-divider division.
  assert property (@(posedge clk) disable iff (rst) (state == ST_CMP) |-> $past(stat.div_done))
    else $error("compare without a fresh quotient");

  // Leaving the compare step for the final rounding only after the last pair.
  assert property (@(posedge clk) disable iff (rst)
      (state == ST_CMP) && (state_next == ST_UP1_START) |-> stat.pre_last && stat.post_last)
    else $error("search ended before the last divider pair");

endmodule

`default_nettype wire

/* src/clock_divider_pair_search_unit.sv */
// Top level of the clock divider pair search unit.
`timescale 1ns / 1ps
`default_nettype none

// A transaction is accepted on a rising edge with start high and busy low;
// the unit then searches every pre-divider from 1 to PRE_MAX and, for each,
// every post-divider from 1 to POST_MAX, keeping the first pair whose rate
// floor(floor(parent/pre)/post) lies closest to the target rate, and finally
// works out the rate rounded up, ceil(ceil(parent/pre)/post), for that pair.
// All divisions share one restoring divider that yields one quotient bit per
// cycle. The result on pre_divisor, post_divisor, rounded_rate and found is
// marked by done, high for exactly one cycle; the receiver cannot stall it,
// and busy stays high until that cycle is over, so one transaction is in
// flight at a time. When no pair beats the starting distance (a zero parent
// rate with the largest target), found is low, both divisors read 1 and
// rounded_rate reads 0.

module clock_divider_pair_search_unit #(
  parameter int PRE_MAX  = cdps_pkg::PRE_MAX_DEF,
  parameter int POST_MAX = cdps_pkg::POST_MAX_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [cdps_pkg::RATE_W-1:0]       target_rate,
  input  wire logic [cdps_pkg::RATE_W-1:0]       source_rate,
  output logic                                   done,
  output logic      [cdps_pkg::PRE_FIELD_W-1:0]  pre_divisor,
  output logic      [cdps_pkg::POST_FIELD_W-1:0] post_divisor,
  output logic      [cdps_pkg::RATE_W-1:0]       rounded_rate,
  output logic                                   found
);

  import cdps_pkg::*;

  // Commands flow from the controller to the datapath; status flows back.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  cdps_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy),
    .done (done)
  );

  cdps_datapath #(
    .PRE_MAX (PRE_MAX),
    .POST_MAX(POST_MAX)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .target_rate (target_rate),
    .source_rate (source_rate),
    .pre_divisor (pre_divisor),
    .post_divisor(post_divisor),
    .rounded_rate(rounded_rate),
    .found       (found)
  );

  // The result strobe only ever appears inside a transaction.
  assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe outside a transaction");

  // An accepted transaction makes the unit busy on the next cycle.
  assert property (@(posedge clk) disable iff (rst) start && !busy |=> busy && !done)
    else $error("accepted transaction did not start the search");

  // The result strobe lasts a single cycle and then the unit is free.
  assert property (@(posedge clk) disable iff (rst) done |=> !done && !busy)
    else $error("result strobe held for more than one cycle");

  // With no pair found, the reported pair is the default one with a zero rate.
  assert property (@(posedge clk) disable iff (rst)
      done && !found |-> (pre_divisor == PRE_FIELD_W'(1)) &&
                          (post_divisor == POST_FIELD_W'(1)) && (rounded_rate == '0))
    else $error("default result not reported when no pair was found");

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for the clock divider pair search unit.
`timescale 1ns / 1ps

module tb_top;

  import cdps_pkg::*;

  // One search result as the unit reports it.
  typedef struct packed {
    logic [PRE_FIELD_W-1:0]  pre_div;
    logic [POST_FIELD_W-1:0] post_div;
    logic [RATE_W-1:0]       rate_up;
    logic                    hit;
  } divider_choice_t;

  localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [RATE_W-1:0] target_rate = '0;
  logic [RATE_W-1:0] source_rate = '0;

  logic                    busy;
  logic                    done;
  logic [PRE_FIELD_W-1:0]  pre_divisor;
  logic [POST_FIELD_W-1:0] post_divisor;
  logic [RATE_W-1:0]       rounded_rate;
  logic                    found;

  // Choices still owed by the unit, oldest first, and the failure count.
  divider_choice_t pending_choices[$];
  int              mismatch_count = 0;

  clock_divider_pair_search_unit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .target_rate  (target_rate),
    .source_rate  (source_rate),
    .done         (done),
    .pre_divisor  (pre_divisor),
    .post_divisor (post_divisor),
    .rounded_rate (rounded_rate),
    .found        (found)
  );

  always #2 clk = ~clk;

  // Exhaustive search over every pre and post divider pair. The distance is
  // worked out at 64 bits so that it never wraps, and only a strictly
  // smaller distance replaces the best, so the earliest pair wins a tie. The
  // rounded rate divides up by the chosen pair, which is (1, 1) when nothing
  // beats the starting distance.
  function automatic divider_choice_t predict_divider_choice(
    input logic [RATE_W-1:0] target,
    input logic [RATE_W-1:0] parent
  );
    logic [63:0]     best;
    logic [63:0]     stage;
    logic [63:0]     quot;
    logic [63:0]     distance;
    logic [63:0]     pre_sel;
    logic [63:0]     post_sel;
    logic [63:0]     up;
    logic            hit;
    divider_choice_t choice;
    best     = 64'(START_DISTANCE);
    pre_sel  = 64'd1;
    post_sel = 64'd1;
    hit      = 1'b0;
    for (int pre = 1; pre <= PRE_MAX_DEF; pre++) begin
      stage = 64'(parent) / 64'(pre);
      for (int post = 1; post <= POST_MAX_DEF; post++) begin
        quot = stage / 64'(post);
        distance = (quot >= 64'(target)) ? quot - 64'(target) : 64'(target) - quot;
        if (distance < best) begin
          best     = distance;
          pre_sel  = 64'(pre);
          post_sel = 64'(post);
          hit      = 1'b1;
        end
      end
    end
    up = (64'(parent) + pre_sel - 64'd1) / pre_sel;
    up = (up + post_sel - 64'd1) / post_sel;
    choice.pre_div  = pre_sel[PRE_FIELD_W-1:0];
    choice.post_div = post_sel[POST_FIELD_W-1:0];
    choice.rate_up  = up[RATE_W-1:0];
    choice.hit      = hit;
    return choice;
  endfunction

  // Presents one request and holds it until the unit takes it. In an idle
  // phase start is dropped at random on any cycle, busy or not, so that the
  // gaps land on every stage of the search and on the cycle busy falls.
  // Start is left as it is on acceptance: the next call or the end of the
  // stimulus decides its value, so it is never assigned twice in one step.
  task automatic send_rate_request(
    input logic [RATE_W-1:0] target,
    input logic [RATE_W-1:0] parent,
    input int                idle_pct
  );
    bit accepted;
    accepted    = 1'b0;
    target_rate <= target;
    source_rate <= parent;
    while (!accepted) begin
      start <= ($urandom_range(99) >= idle_pct);
      @(posedge clk);
      if (start && !busy) begin
        accepted = 1'b1;
        pending_choices.push_back(predict_divider_choice(target, parent));
      end
    end
  endtask

  // A rate of random magnitude, so that small and large rates both turn up.
  function automatic logic [RATE_W-1:0] random_rate();
    return RATE_W'($urandom) >> $urandom_range(RATE_W - 1);
  endfunction

  // Field extremes, alternating bit patterns and every named special case:
  // the search that finds nothing, ties between pairs, a target above every
  // reachable rate and rounding up through both divisions.
  task automatic test_directed_cases();
    send_rate_request('0, '0, 0);                       // every pair ties at zero
    send_rate_request(RATE_MAX, '0, 0);                 // nothing beats the start
    send_rate_request(RATE_MAX - 1, '0, 0);             // first pair just beats it
    send_rate_request(RATE_MAX, RATE_MAX, 0);
    send_rate_request('0, RATE_MAX, 0);                 // deepest division wins
    send_rate_request(31'd1, 31'd1, 0);
    send_rate_request(31'd6, 31'd12, 0);                // (1,2) and (2,1) tie
    send_rate_request(31'd5, 31'd24, 0);                // many near ties
    send_rate_request(31'd333, 31'd1000001, 0);         // rounding up both steps
    send_rate_request(31'h2AAAAAAA, 31'h55555555, 0);
    send_rate_request(31'h55555555, 31'h2AAAAAAA, 0);
    send_rate_request(31'd24000000, 31'd800000000, 0);
    send_rate_request(RATE_MAX, 31'd1, 0);              // target far above parent
    send_rate_request(31'd1, RATE_MAX, 0);
  endtask

  // Mostly targets placed close to a rate some pair can reach, so that exact
  // hits, ties and near misses are common; the rest are unrelated rates.
  task automatic test_random_rates(input int count, input int idle_pct);
    logic [RATE_W-1:0] parent;
    logic [RATE_W-1:0] target;
    logic [RATE_W-1:0] reach;
    for (int i = 0; i < count; i++) begin
      parent = ($urandom_range(3) == 0) ? RATE_W'($urandom) : random_rate();
      if ($urandom_range(3) != 0) begin
        reach  = parent / RATE_W'($urandom_range(1, PRE_MAX_DEF))
                        / RATE_W'($urandom_range(1, POST_MAX_DEF));
        target = reach + RATE_W'($urandom_range(8)) - RATE_W'(4);
      end else begin
        target = ($urandom_range(1) == 0) ? RATE_W'($urandom) : random_rate();
      end
      send_rate_request(target, parent, idle_pct);
    end
  endtask

  // Compare each result with the oldest expectation. Outputs are read just
  // after the edge, so they still hold the values of the cycle that ended.
  task automatic report_field(input string field, input longint exp_val,
                              input longint act_val);
    if (exp_val != act_val) begin
      mismatch_count++;
      $display("%0t ns: %s mismatch: expected %0d, actual %0d",
               $time, field, exp_val, act_val);
    end
  endtask

  divider_choice_t oldest_choice;

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_choices.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: unexpected result: expected none, actual pre %0d post %0d",
                 $time, pre_divisor, post_divisor);
      end else begin
        oldest_choice = pending_choices.pop_front();
        report_field("pre_divisor", oldest_choice.pre_div, pre_divisor);
        report_field("post_divisor", oldest_choice.post_div, post_divisor);
        report_field("rounded_rate", oldest_choice.rate_up, rounded_rate);
        report_field("found", oldest_choice.hit, found);
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_random_rates(30, 0);
    test_random_rates(30, 67);
    test_random_rates(30, 19);
    start <= 1'b0;
    while (pending_choices.size() != 0) @(posedge clk);
    // Give a stray extra result time to show itself.
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && pending_choices.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // About 105 searches take under 8 ms; the limit allows for slightly more
  // than three times that.
  initial begin
    #25_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
